// ===== rtl/fls_pkg.sv =====
// Shared types and constants for the free list slot allocator.
// Used by fls_ctrl, fls_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package fls_pkg;

   // Request kinds carried on req_tuser
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Result status codes carried on rsp_tuser
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_NOT_LIVE = 2'd2;

   // Field widths of the channels
   localparam int SLOT_W      = 8;
   localparam int REV_W       = 16;
   localparam int COUNT_W     = 9;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // take the request and start the memory read
      logic commit;    // update state and load the result register
   } fls_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rsp_hold;  // result register full and not being taken
   } fls_stat_type;

endpackage

// ===== rtl/fls_ctrl.sv =====
// Sequencing state machine of the free list slot allocator.
// Depends on fls_pkg for the command and status structs.
`timescale 1ns / 1ps

module fls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  fls_pkg::fls_stat_type stat,
   output fls_pkg::fls_cmd_type  cmd
);

   typedef enum logic {
      IDLE,
      EXEC
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_tready  = ready_ff;
   assign cmd.capture = ready_ff && req_tvalid;
   assign cmd.commit  = (state_ff == EXEC) && !stat.rsp_hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (cmd.capture) begin
                  state_ff <= EXEC;
                  ready_ff <= 1'b0;
               end
            end
            EXEC: begin
               // hold until the result register can take the item
               if (cmd.commit) begin
                  state_ff <= IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

// ===== rtl/fls_datapath.sv =====
// Datapath of the free list slot allocator: link and slot memories,
// list head, fill mark, live count and the result register. Uses fls_pkg.
`timescale 1ns / 1ps

module fls_datapath #(
   parameter int POOL_SLOTS    = 256,
   parameter int REVISION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  fls_pkg::fls_cmd_type               cmd,
   output fls_pkg::fls_stat_type              stat,
   input  logic                               req_func,
   input  logic [fls_pkg::SLOT_W-1:0]         req_slot,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [fls_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic [fls_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int SLOT_BITS = $clog2(POOL_SLOTS);
   localparam int LINK_BITS = $clog2(POOL_SLOTS + 1);
   localparam int WIDE_BITS = LINK_BITS + fls_pkg::SLOT_W;
   localparam int PAD_BITS  = fls_pkg::RSP_DATA_W - fls_pkg::SLOT_W - fls_pkg::REV_W
                              - fls_pkg::COUNT_W;
   localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(POOL_SLOTS);
   localparam logic [LINK_BITS-1:0] ONE_LINK  = LINK_BITS'(1);
   localparam logic [REVISION_BITS-1:0] ONE_REV = REVISION_BITS'(1);

   typedef struct packed {
      logic                     live;
      logic [REVISION_BITS-1:0] rev;
   } slot_state_type;

   // memories
   logic [LINK_BITS-1:0] link_mem  [POOL_SLOTS];
   slot_state_type       state_mem [POOL_SLOTS];

   // control state
   logic [LINK_BITS-1:0] head_ff, head_in;
   logic [LINK_BITS-1:0] fill_ff, fill_in;
   logic [LINK_BITS-1:0] live_ff, live_in;
   logic                 rsp_valid_ff;

   // request and read data registers
   logic                      func_ff;
   logic [fls_pkg::SLOT_W-1:0] idx_ff;
   logic                      fresh_ff;
   logic [LINK_BITS-1:0]      link_rd_ff;
   slot_state_type            state_rd_ff;

   // result registers
   logic [fls_pkg::STATUS_W-1:0]   rsp_user_ff, rsp_user_in;
   logic [fls_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [WIDE_BITS-1:0]     idx_wide, head_wide, fill_wide, rd_wide;
   logic [SLOT_BITS-1:0]     rd_addr, wr_addr;
   logic [WIDE_BITS-1:0]     idx_ff_wide;
   logic                     link_we, state_we;
   logic [LINK_BITS-1:0]     link_wdata;
   slot_state_type           state_wdata;
   logic [REVISION_BITS-1:0] old_rev, rev_out;
   logic [fls_pkg::SLOT_W-1:0] granted;
   logic [31+REVISION_BITS:0]  rev_wide;
   logic [WIDE_BITS-1:0]       live_wide;

   assign idx_wide  = {{LINK_BITS{1'b0}}, req_slot};
   assign head_wide = {{fls_pkg::SLOT_W{1'b0}}, head_ff};
   assign fill_wide = {{fls_pkg::SLOT_W{1'b0}}, fill_ff};
   assign rd_wide   = (req_func == fls_pkg::FUNC_FREE) ? idx_wide : head_wide;
   assign rd_addr   = rd_wide[SLOT_BITS-1:0];

   // read port: a slot at or above the fill mark was never allocated
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff     <= req_func;
         idx_ff      <= req_slot;
         fresh_ff    <= (rd_wide >= fill_wide);
         link_rd_ff  <= link_mem[rd_addr];
         state_rd_ff <= state_mem[rd_addr];
      end
   end

   assign idx_ff_wide = {{LINK_BITS{1'b0}}, idx_ff};
   assign old_rev     = fresh_ff ? '0 : state_rd_ff.rev;

   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      live_in     = live_ff;
      link_we     = 1'b0;
      state_we    = 1'b0;
      wr_addr     = head_wide[SLOT_BITS-1:0];
      link_wdata  = head_ff;
      state_wdata = state_rd_ff;
      rsp_user_in = fls_pkg::STATUS_OK;
      granted     = '0;
      rev_out     = '0;
      if (func_ff == fls_pkg::FUNC_ALLOC) begin
         if (head_ff == NULL_LINK) begin
            rsp_user_in = fls_pkg::STATUS_EMPTY;
         end else begin
            // pop the head; a fresh slot links to its successor
            state_we         = 1'b1;
            state_wdata.live = 1'b1;
            state_wdata.rev  = old_rev + ONE_REV;
            head_in          = fresh_ff ? (head_ff + ONE_LINK) : link_rd_ff;
            fill_in          = fresh_ff ? (fill_ff + ONE_LINK) : fill_ff;
            live_in          = live_ff + ONE_LINK;
            granted          = head_wide[fls_pkg::SLOT_W-1:0];
            rev_out          = old_rev + ONE_REV;
         end
      end else begin
         wr_addr = idx_ff_wide[SLOT_BITS-1:0];
         rev_out = old_rev;
         if (fresh_ff || !state_rd_ff.live) begin
            rsp_user_in = fls_pkg::STATUS_NOT_LIVE;
         end else begin
            // push the slot back on the head
            link_we          = 1'b1;
            state_we         = 1'b1;
            state_wdata.live = 1'b0;
            head_in          = idx_ff_wide[LINK_BITS-1:0];
            live_in          = live_ff - ONE_LINK;
         end
      end
   end

   assign rev_wide    = {32'd0, rev_out};
   assign live_wide   = {{fls_pkg::SLOT_W{1'b0}}, live_in};
   assign rsp_data_in = {{PAD_BITS{1'b0}},
                         live_wide[fls_pkg::COUNT_W-1:0],
                         rev_wide[fls_pkg::REV_W-1:0],
                         granted};

   // write port
   always_ff @(posedge clock) begin
      if (cmd.commit && link_we) begin
         link_mem[wr_addr] <= link_wdata;
      end
      if (cmd.commit && state_we) begin
         state_mem[wr_addr] <= state_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            head_ff      <= head_in;
            fill_ff      <= fill_in;
            live_ff      <= live_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_user_ff <= rsp_user_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign stat.rsp_hold = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tuser     = rsp_user_ff;
   assign rsp_tdata     = rsp_data_ff;

endmodule

// ===== rtl/free_list_slot_allocator.sv =====
// Top level of the free list slot allocator.
// Joins fls_ctrl and fls_datapath; types and codes come from fls_pkg.
//
// Usage:
//   The req_ channel carries one request per item: req_tuser selects
//   allocate or free, req_tdata names the slot to free (ignored on
//   allocate). The rsp_ channel returns exactly one result item per
//   request: rsp_tuser holds the status, rsp_tdata the granted slot,
//   the slot revision and the live count after the request.
//   An allocate pops the head of the free list and bumps that slot's
//   revision; a free pushes a live slot back on the head. Allocating
//   from an empty pool and freeing a slot that is not live change nothing
//   and report their status code.
//   Sequence: at acceptance the request is registered and the slot
//   memories are read into registers; the controller then moves to EXEC
//   and, once the result register is free, commits the update and loads
//   the result, raising rsp_tvalid. req_tready stays low from acceptance
//   to commit: the next allocate needs the new head from the link memory.
//   Reset: the free list chains slots 0 to POOL_SLOTS-1 in order, all
//   revisions read zero and nothing is live. A fill mark stands in for the
//   memory reset, so no clearing pass is needed and requests are taken
//   as soon as reset is released.
//   Stall: while a result waits on rsp_tready, the next request may still
//   be taken; its update then holds until the result register frees up.
`timescale 1ns / 1ps

module free_list_slot_allocator #(
   parameter int POOL_SLOTS    = 256,
   parameter int REVISION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fls_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] slot_index
   input  logic                               req_tuser,   // [0] func
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] granted_slot, [23:8] slot_revision, [32:24] live_count, [39:33] zero
   output logic [fls_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [fls_pkg::STATUS_W-1:0]       rsp_tuser    // [1:0] status
);

   fls_pkg::fls_cmd_type  cmd;
   fls_pkg::fls_stat_type stat;

   // sequencing: accept, then commit once the result register is free
   fls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // free list, slot state and result register
   fls_datapath #(
      .POOL_SLOTS    (POOL_SLOTS),
      .REVISION_BITS (REVISION_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_func   (req_tuser),
      .req_slot   (req_tdata[fls_pkg::SLOT_W-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
